/* src/clr_pkg.sv */
// Package for the clipped line rasterizer: payload structs, config indexes,
// and shared constants. No dependencies.
`timescale 1ns / 1ps
package clr_pkg;

  localparam int unsigned MaxScreenDimDefault = 4096;
  localparam int unsigned TFracBitsDefault    = 20;
  localparam int unsigned CfgIdxW             = 1;
  localparam int unsigned CfgDataW            = 13;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_SCREEN_WIDTH  = 1'b0,
    CFG_SCREEN_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    MODE_LOAD = 1'b0,
    MODE_STEP = 1'b1
  } mode_e;

  typedef struct packed {
    logic               mode;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic [7:0]         line_red;
    logic [7:0]         line_green;
    logic [7:0]         line_blue;
  } in_item_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic       last_pixel;
    logic       line_rejected;
  } out_item_t;

endpackage

/* src/clr_divider.sv */
// Restoring radix-2 divider for the clip ratios, one quotient bit per cycle.
// Depends on clr_pkg only through the import convention.
`timescale 1ns / 1ps
module clr_divider import clr_pkg::*; #(
  parameter int unsigned NumW = 38,
  parameter int unsigned DenW = 18
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [NumW-1:0] num_i,
  input  logic [DenW-1:0] den_i,
  output logic            done_o,
  output logic [NumW-1:0] quot_o
);
  localparam int unsigned CntW = $clog2(NumW + 1);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic [NumW-1:0] quot_q, quot_d;
  logic [DenW:0]   rem_q, rem_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DenW:0]   trial;

  always_comb begin
    busy_d = busy_q;
    cnt_d  = cnt_q;
    quot_d = quot_q;
    rem_d  = rem_q;
    den_d  = den_q;
    trial  = {rem_q[DenW-1:0], quot_q[NumW-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NumW);
      quot_d = num_i;
      rem_d  = '0;
      den_d  = den_i;
    end else if (busy_q) begin
      quot_d = {quot_q[NumW-2:0], 1'b0};
      if (trial >= {1'b0, den_q}) begin
        rem_d     = trial - {1'b0, den_q};
        quot_d[0] = 1'b1;
      end else begin
        rem_d = trial;
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quot_q <= quot_d;
    rem_q  <= rem_d;
    den_q  <= den_d;
  end

  assign done_o = busy_q && (cnt_q == CntW'(1)) && !start_i;
  assign quot_o = quot_d;
endmodule

/* src/clr_front.sv */
// Front end: accepts items, runs the Liang-Barsky clip for loads and pushes
// an operation into the queue. Depends on clr_pkg and clr_divider.
`timescale 1ns / 1ps
module clr_front import clr_pkg::*; #(
  parameter int unsigned MaxScreenDim = MaxScreenDimDefault,
  parameter int unsigned TFracBits    = TFracBitsDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_item_i,
  input  logic [12:0] width_i,
  input  logic [12:0] height_i,
  output logic        op_valid_o,
  input  logic        op_ready_i,
  output logic        op_step_o,
  output logic        op_reject_o,
  output logic [11:0] op_bx_o,
  output logic [11:0] op_by_o,
  output logic [11:0] op_ex_o,
  output logic [11:0] op_ey_o,
  output logic [23:0] op_colour_o
);
  localparam int unsigned TW   = TFracBits + 2;
  localparam int unsigned NumW = 18 + TFracBits;
  localparam int unsigned ProdW = TW + 18;
  localparam logic [TW-1:0] TOne = TW'(1) << TFracBits;
  localparam logic [13:0] MaxDim = 14'(MaxScreenDim);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b00000001,
    S_EDGE  = 8'b00000010,
    S_DIV   = 8'b00000100,
    S_CUT   = 8'b00001000,
    S_MUL   = 8'b00010000,
    S_FIN   = 8'b00100000,
    S_PUSH  = 8'b01000000,
    S_STEP  = 8'b10000000
  } state_e;

  state_e state_q, state_d;
  logic signed [17:0] x0_q, y0_q, dx_q, dy_q;
  logic signed [17:0] wmax_q, hmax_q;
  logic [TW-1:0] t0_q, t0_d, t1_q, t1_d;
  logic [1:0] edge_q, edge_d;
  logic [1:0] cut_q, cut_d;
  logic ok_q, ok_d;
  logic [11:0] bx_q, by_q, ex_q, ey_q;
  logic [23:0] col_q;
  logic signed [17:0] p, q;
  logic signed [17:0] ap, aq;
  logic div_start, div_done;
  logic [NumW-1:0] quot;
  logic [TW-1:0] r_sat;
  logic [13:0] wdim, hdim;
  logic signed [17:0] c_start, c_delta, c_hi;
  logic [TW-1:0] c_t;
  logic signed [ProdW-1:0] prod_q;
  logic signed [ProdW-1:0] sum;
  logic signed [ProdW-TFracBits-1:0] flo;
  logic [11:0] clamped;
  logic signed [17:0] nx0, ny0, ndx, ndy;

  always_comb begin
    wdim = (width_i == 13'd0) ? 14'd1 : ({1'b0, width_i} > MaxDim ? MaxDim : {1'b0, width_i});
    hdim = (height_i == 13'd0) ? 14'd1 :
           ({1'b0, height_i} > MaxDim ? MaxDim : {1'b0, height_i});
    nx0 = 18'(in_item_i.start_x);
    ny0 = 18'(in_item_i.start_y);
    ndx = 18'(in_item_i.end_x) - 18'(in_item_i.start_x);
    ndy = 18'(in_item_i.end_y) - 18'(in_item_i.start_y);
  end

  always_comb begin
    unique case (edge_q)
      2'd0: begin p = -dx_q; q = x0_q; end
      2'd1: begin p = dx_q;  q = wmax_q - x0_q; end
      2'd2: begin p = -dy_q; q = y0_q; end
      default: begin p = dy_q; q = hmax_q - y0_q; end
    endcase
    ap = p[17] ? -p : p;
    aq = q[17] ? -q : q;
  end

  assign div_start = (state_q == S_EDGE) && (p != 0) && !(q != 0 && (p[17] != q[17]));

  clr_divider #(.NumW(NumW), .DenW(18)) u_div (
    .clk_i, .rst_ni,
    .start_i(div_start),
    .num_i({aq, {TFracBits{1'b0}}}),
    .den_i(ap),
    .done_o(div_done),
    .quot_o(quot)
  );

  assign r_sat = (quot > NumW'(TOne + 1'b1)) ? TOne + 1'b1 : TW'(quot);

  always_comb begin
    unique case (cut_q)
      2'd0: begin c_start = x0_q; c_delta = dx_q; c_t = t1_q; c_hi = wmax_q; end
      2'd1: begin c_start = y0_q; c_delta = dy_q; c_t = t1_q; c_hi = hmax_q; end
      2'd2: begin c_start = x0_q; c_delta = dx_q; c_t = t0_q; c_hi = wmax_q; end
      default: begin c_start = y0_q; c_delta = dy_q; c_t = t0_q; c_hi = hmax_q; end
    endcase
    // Arithmetic shift of the sum is the floor division by 2^F.
    sum = prod_q + (ProdW'(c_start) <<< TFracBits);
    flo = sum[ProdW-1:TFracBits];
    if (flo < 0) clamped = '0;
    else if (flo > (ProdW-TFracBits)'(c_hi)) clamped = c_hi[11:0];
    else clamped = flo[11:0];
  end

  always_comb begin
    state_d = state_q;
    t0_d = t0_q;
    t1_d = t1_q;
    edge_d = edge_q;
    cut_d = cut_q;
    ok_d = ok_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (in_item_i.mode == MODE_STEP) state_d = S_STEP;
          else begin
            state_d = S_EDGE;
            t0_d = '0;
            t1_d = TOne;
            edge_d = 2'd0;
            ok_d = 1'b1;
          end
        end
      end
      S_EDGE: begin
        if (p == 0) begin
          if (q[17]) begin ok_d = 1'b0; state_d = S_PUSH; end
          else if (edge_q == 2'd3) begin state_d = S_CUT; cut_d = 2'd0; end
          else edge_d = edge_q + 1'b1;
        end else if (q != 0 && (p[17] != q[17])) begin
          if (p[17]) begin
            if (edge_q == 2'd3) begin state_d = S_CUT; cut_d = 2'd0; end
            else edge_d = edge_q + 1'b1;
          end else begin ok_d = 1'b0; state_d = S_PUSH; end
        end else state_d = S_DIV;
      end
      S_DIV: begin
        if (div_done) begin
          if (p[17]) begin
            if (r_sat > t1_q) ok_d = 1'b0;
            else if (r_sat > t0_q) t0_d = r_sat;
          end else begin
            if (r_sat < t0_q) ok_d = 1'b0;
            else if (r_sat < t1_q) t1_d = r_sat;
          end
          if ((p[17] && r_sat > t1_q) || (!p[17] && r_sat < t0_q)) state_d = S_PUSH;
          else if (edge_q == 2'd3) begin state_d = S_CUT; cut_d = 2'd0; end
          else begin edge_d = edge_q + 1'b1; state_d = S_EDGE; end
        end
      end
      S_CUT: state_d = S_MUL;
      S_MUL: state_d = S_FIN;
      S_FIN: begin
        if (cut_q == 2'd3) state_d = S_PUSH;
        else begin cut_d = cut_q + 1'b1; state_d = S_CUT; end
      end
      S_PUSH: if (op_ready_i) state_d = S_IDLE;
      S_STEP: if (op_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      edge_q <= '0;
      cut_q <= '0;
      ok_q <= 1'b0;
    end else begin
      state_q <= state_d;
      edge_q <= edge_d;
      cut_q <= cut_d;
      ok_q <= ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    t0_q <= t0_d;
    t1_q <= t1_d;
    if (state_q == S_IDLE && in_valid_i) begin
      x0_q <= nx0;
      y0_q <= ny0;
      dx_q <= ndx;
      dy_q <= ndy;
      wmax_q <= 18'(wdim) - 18'sd1;
      hmax_q <= 18'(hdim) - 18'sd1;
      col_q <= {in_item_i.line_red, in_item_i.line_green, in_item_i.line_blue};
    end
    if (state_q == S_MUL) prod_q <= $signed({1'b0, c_t}) * c_delta;
    if (state_q == S_FIN) begin
      unique case (cut_q)
        2'd0: ex_q <= clamped;
        2'd1: ey_q <= clamped;
        2'd2: bx_q <= clamped;
        default: by_q <= clamped;
      endcase
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign op_valid_o  = (state_q == S_PUSH) || (state_q == S_STEP);
  assign op_step_o   = (state_q == S_STEP);
  assign op_reject_o = !ok_q;
  assign op_bx_o = bx_q;
  assign op_by_o = by_q;
  assign op_ex_o = ex_q;
  assign op_ey_o = ey_q;
  assign op_colour_o = col_q;
endmodule

/* src/clr_back.sv */
// Back end: pops operations from a two-entry queue, keeps the Bresenham
// state and drives the output register. Depends on clr_pkg.
`timescale 1ns / 1ps
module clr_back import clr_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        op_valid_i,
  output logic        op_ready_o,
  input  logic        op_step_i,
  input  logic        op_reject_i,
  input  logic [11:0] op_bx_i,
  input  logic [11:0] op_by_i,
  input  logic [11:0] op_ex_i,
  input  logic [11:0] op_ey_i,
  input  logic [23:0] op_colour_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_item_o
);
  localparam int unsigned OpW = 1 + 1 + 48 + 24;

  logic [OpW-1:0] fifo_q [2];
  logic [1:0] cnt_q, cnt_d;
  logic wr_ptr_q, rd_ptr_q;
  logic push, pop;
  logic [OpW-1:0] head;
  logic h_step, h_rej;
  logic [11:0] h_bx, h_by, h_ex, h_ey;
  logic [23:0] h_col;

  logic active_q, active_d;
  logic [11:0] cx_q, cx_d, cy_q, cy_d, tx_q, tx_d, ty_q, ty_d;
  logic signed [13:0] dxa_q, dxa_d;
  logic signed [14:0] dyn_q, dyn_d;
  logic signed [15:0] err_q, err_d;
  logic [1:0] sgn_q, sgn_d;
  logic [23:0] col_q, col_d;
  logic signed [12:0] ax, ay;
  logic signed [16:0] e2;
  logic signed [15:0] err_t;
  logic out_valid_q;
  out_item_t out_q, out_d;

  assign op_ready_o = (cnt_q != 2'd2);
  assign push = op_valid_i && op_ready_o;
  assign pop  = (cnt_q != 2'd0) && (!out_valid_q || out_ready_i);
  assign head = fifo_q[rd_ptr_q];
  assign {h_step, h_rej, h_bx, h_by, h_ex, h_ey, h_col} = head;

  always_comb begin
    cnt_d = cnt_q + {1'b0, push} - {1'b0, pop};
    active_d = active_q;
    cx_d = cx_q; cy_d = cy_q; tx_d = tx_q; ty_d = ty_q;
    dxa_d = dxa_q; dyn_d = dyn_q; err_d = err_q; sgn_d = sgn_q; col_d = col_q;
    out_d = '0;
    ax = $signed({1'b0, h_ex}) - $signed({1'b0, h_bx});
    ay = $signed({1'b0, h_ey}) - $signed({1'b0, h_by});
    e2 = 17'(err_q) <<< 1;
    err_t = err_q;
    if (pop) begin
      if (!h_step) begin
        col_d = h_col;
        if (h_rej) begin
          active_d = 1'b0;
          out_d.line_rejected = 1'b1;
        end else begin
          active_d = 1'b1;
          cx_d = h_bx; cy_d = h_by; tx_d = h_ex; ty_d = h_ey;
          dxa_d = ax[12] ? -14'(ax) : 14'(ax);
          dyn_d = ay[12] ? 15'(ay) : -15'(ay);
          err_d = 16'(dxa_d) + 16'(dyn_d);
          sgn_d = {(h_by >= h_ey), (h_bx >= h_ex)};
        end
      end else if (active_q) begin
        out_d.pixel_valid = 1'b1;
        out_d.pixel_x = cx_q;
        out_d.pixel_y = cy_q;
        {out_d.pixel_red, out_d.pixel_green, out_d.pixel_blue} = col_q;
        if (cx_q == tx_q && cy_q == ty_q) begin
          out_d.last_pixel = 1'b1;
          active_d = 1'b0;
        end else begin
          if (e2 >= 17'(dyn_q)) begin
            err_t = err_t + 16'(dyn_q);
            cx_d = sgn_q[0] ? cx_q - 12'd1 : cx_q + 12'd1;
          end
          if (e2 <= 17'(dxa_q)) begin
            err_t = err_t + 16'(dxa_q);
            cy_d = sgn_q[1] ? cy_q - 12'd1 : cy_q + 12'd1;
          end
          err_d = err_t;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      active_q <= 1'b0;
      out_valid_q <= 1'b0;
      cx_q <= '0; cy_q <= '0; tx_q <= '0; ty_q <= '0;
      dxa_q <= '0; dyn_q <= '0; err_q <= '0; sgn_q <= '0; col_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push) wr_ptr_q <= !wr_ptr_q;
      if (pop) rd_ptr_q <= !rd_ptr_q;
      active_q <= active_d;
      cx_q <= cx_d; cy_q <= cy_d; tx_q <= tx_d; ty_q <= ty_d;
      dxa_q <= dxa_d; dyn_q <= dyn_d; err_q <= err_d; sgn_q <= sgn_d; col_q <= col_d;
      if (pop) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= {op_step_i, op_reject_i, op_bx_i, op_by_i,
                                   op_ex_i, op_ey_i, op_colour_i};
    if (pop) out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;
endmodule

/* src/clipped_line_rasterizer_core.sv */
// Channel    Handshake                      Payload
// input      in_valid_i / in_ready_o        in_item_i (in_item_t)
// output     out_valid_o / out_ready_i      out_item_o (out_item_t)
// config     cfg_we_i                       cfg_idx_i, cfg_data_i
// A step request passes the front-end step state and the back-end queue before it reaches
// the output register, and the front end takes no new request until it has pushed the last.
// A load request tests the left, right, top and bottom edges in turn, each test possibly needing a restoring division,
// then cuts the x and y of both endpoints on one shared multiplier.
// Reset clears all control state and the back end's line state; config returns to 640 by 480.
// The output register holds a result until taken; the queue lets the front keep working.
// Top level of the clipped line rasterizer; depends on clr_pkg, clr_front, clr_back.
`timescale 1ns / 1ps
module clipped_line_rasterizer_core import clr_pkg::*; #(
  parameter int unsigned MaxScreenDim = MaxScreenDimDefault,
  parameter int unsigned TFracBits    = TFracBitsDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  in_item_t            in_item_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output out_item_t           out_item_o,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i
);
  logic [12:0] width_q, height_q;
  logic op_valid, op_ready, op_step, op_reject;
  logic [11:0] op_bx, op_by, op_ex, op_ey;
  logic [23:0] op_colour;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 13'd640;
      height_q <= 13'd480;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SCREEN_WIDTH:  width_q  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  clr_front #(.MaxScreenDim(MaxScreenDim), .TFracBits(TFracBits)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_item_i,
    .width_i(width_q), .height_i(height_q),
    .op_valid_o(op_valid), .op_ready_i(op_ready), .op_step_o(op_step),
    .op_reject_o(op_reject), .op_bx_o(op_bx), .op_by_o(op_by),
    .op_ex_o(op_ex), .op_ey_o(op_ey), .op_colour_o(op_colour)
  );

  clr_back u_back (
    .clk_i, .rst_ni,
    .op_valid_i(op_valid), .op_ready_o(op_ready), .op_step_i(op_step),
    .op_reject_i(op_reject), .op_bx_i(op_bx), .op_by_i(op_by),
    .op_ex_i(op_ex), .op_ey_i(op_ey), .op_colour_i(op_colour),
    .out_valid_o, .out_ready_i, .out_item_o
  );

`ifndef ASSERT_OFF
  a_rej_no_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.line_rejected |-> !out_item_o.pixel_valid)
    else $error("rejected load carries a pixel");
  a_last_has_pixel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.last_pixel |-> out_item_o.pixel_valid)
    else $error("last flag without pixel");
  a_x_in_window: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_item_o.pixel_valid |-> (out_item_o.pixel_x < 12'(MaxScreenDim - 1) ||
      out_item_o.pixel_x == 12'(MaxScreenDim - 1)))
    else $error("pixel outside window");
`endif
endmodule
